[hdl/iwi_pkg.sv]
// Shared types, widths and arithmetic helpers for the indicated work integrator.
package iwi_pkg;

  localparam int PRESS_W = 20;
  localparam int VOL_W   = 24;
  localparam int DP_W    = PRESS_W + 2;
  localparam int DV_W    = VOL_W + 1;
  localparam int INC_W   = DP_W + DV_W;
  localparam int WORK_W  = 64;

  localparam logic [PRESS_W-1:0] AMBIENT_RESET = PRESS_W'(1621);

  // Work increment and the control flags that travel with it.
  typedef struct packed {
    logic                    taken;
    logic                    do_inc;
    logic                    close;
    logic                    gas;
    logic                    exh;
    logic signed [INC_W-1:0] inc;
  } inc_t;

  // Signed add of an increment to a sum, clamped at the 64-bit limits.
  function automatic logic signed [WORK_W-1:0] sat_add(
    input logic signed [WORK_W-1:0] a,
    input logic signed [INC_W-1:0]  b
  );
    logic signed [WORK_W:0] s;
    logic signed [WORK_W:0] ax;
    logic signed [WORK_W:0] bx;
    ax = {a[WORK_W-1], a};
    bx = {{(WORK_W + 1 - INC_W){b[INC_W-1]}}, b};
    s  = ax + bx;
    if (s[WORK_W] != s[WORK_W-1]) begin
      if (s[WORK_W]) begin
        sat_add = {1'b1, {(WORK_W-1){1'b0}}};
      end else begin
        sat_add = {1'b0, {(WORK_W-1){1'b1}}};
      end
    end else begin
      sat_add = s[WORK_W-1:0];
    end
  endfunction

endpackage

[hdl/iwi_increment.sv]
// Increment stage: trapezoidal gauge-pressure work increment and the previous-sample state.
module iwi_increment (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic [iwi_pkg::PRESS_W-1:0]    ambient,
  input  logic [iwi_pkg::PRESS_W-1:0]    pressure,
  input  logic [iwi_pkg::VOL_W-1:0]      volume,
  input  logic                           boundary,
  input  logic                           gas,
  input  logic                           exh,
  output iwi_pkg::inc_t                  stage
);
  import iwi_pkg::*;

  logic [PRESS_W-1:0]     last_pressure;
  logic [VOL_W-1:0]       last_volume;
  logic                   primed;
  logic signed [DP_W-1:0] dp;
  logic signed [DV_W-1:0] dv;
  logic [INC_W-1:0]       prod;
  logic                   taken;

  // Mean-pressure difference against ambient (times two) and the volume change.
  assign taken = (volume != '0);
  assign dp = $signed({2'b00, last_pressure}) + $signed({2'b00, pressure})
              - $signed({1'b0, ambient, 1'b0});
  assign dv = $signed({1'b0, volume}) - $signed({1'b0, last_volume});
  assign prod = {{(INC_W-DP_W){dp[DP_W-1]}}, dp} * {{(INC_W-DV_W){dv[DV_W-1]}}, dv};

  // Previous-sample state moves only on a valid sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pressure <= '0;
      last_volume   <= '0;
      primed        <= 1'b0;
    end else if (load && taken) begin
      last_pressure <= pressure;
      last_volume   <= volume;
      primed        <= 1'b1;
    end
  end

  // Product register with the flags of the same item.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.taken  <= 1'b0;
      stage.do_inc <= 1'b0;
      stage.close  <= 1'b0;
      stage.gas    <= 1'b0;
      stage.exh    <= 1'b0;
      stage.inc    <= '0;
    end else if (load) begin
      stage.taken  <= taken;
      stage.do_inc <= taken && primed;
      stage.close  <= taken && primed && boundary;
      stage.gas    <= gas;
      stage.exh    <= gas && exh;
      stage.inc    <= $signed(prod);
    end
  end

endmodule

[hdl/iwi_accum.sv]
// Accumulate stage: saturating sums, completed-cycle latches and the result flags.
module iwi_accum (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  iwi_pkg::inc_t                  stage,
  output logic                           sample_taken,
  output logic                           cycle_closed,
  output logic [iwi_pkg::WORK_W-1:0]     cycle_work,
  output logic [iwi_pkg::WORK_W-1:0]     pumping_work,
  output logic [iwi_pkg::WORK_W-1:0]     exhaust_work
);
  import iwi_pkg::*;

  logic signed [WORK_W-1:0] sum_total;
  logic signed [WORK_W-1:0] sum_pumping;
  logic signed [WORK_W-1:0] sum_exhaust;
  logic signed [WORK_W-1:0] sum_total_next;
  logic signed [WORK_W-1:0] sum_pumping_next;
  logic signed [WORK_W-1:0] sum_exhaust_next;

  // Sums after this item's increment.
  always_comb begin
    sum_total_next   = sum_total;
    sum_pumping_next = sum_pumping;
    sum_exhaust_next = sum_exhaust;
    if (stage.do_inc) begin
      sum_total_next = sat_add(sum_total, stage.inc);
      if (stage.gas) begin
        sum_pumping_next = sat_add(sum_pumping, stage.inc);
      end
      if (stage.exh) begin
        sum_exhaust_next = sat_add(sum_exhaust, stage.inc);
      end
    end
  end

  // On a cycle boundary the sums move to the completed values and restart.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_total    <= '0;
      sum_pumping  <= '0;
      sum_exhaust  <= '0;
      cycle_work   <= '0;
      pumping_work <= '0;
      exhaust_work <= '0;
      sample_taken <= 1'b0;
      cycle_closed <= 1'b0;
    end else if (load) begin
      sample_taken <= stage.taken;
      cycle_closed <= stage.close;
      if (stage.close) begin
        cycle_work   <= sum_total_next;
        pumping_work <= sum_pumping_next;
        exhaust_work <= sum_exhaust_next;
        sum_total    <= '0;
        sum_pumping  <= '0;
        sum_exhaust  <= '0;
      end else begin
        sum_total    <= sum_total_next;
        sum_pumping  <= sum_pumping_next;
        sum_exhaust  <= sum_exhaust_next;
      end
    end
  end

endmodule

[hdl/indicated_work_integrator.sv]
// Top level of the indicated work integrator: input register, pipeline control, config.
//
// Usage:
//   The slave stream takes one pressure/volume sample per item. s_tlast flags an
//   engine cycle boundary, s_tuser carries the stroke flags. The master stream
//   gives one result per item: m_tuser says the sample was used, m_tlast says a
//   cycle was closed, m_tdata holds the last completed total, pumping and exhaust
//   work sums (1/32 microjoule, saturated at the signed 64-bit limits).
//   Users write the ambient pressure register (cfg_we/cfg_data) only while idle; not enforced.
// Timing:
//   Three register stages (input, product, accumulate/result); an accepted item
//   moves through the product and then the accumulate register. One item per cycle is
//   sustained while m_tready is high, set by the 64-bit saturating accumulate loop.
// Reset:
//   rst empties the pipeline, clears the sums and completed values and loads
//   the ambient register with 1621 (101.3 kPa).
// Stall:
//   While m_tready is low the result holds; earlier stages keep filling until all
//   three are occupied, then s_tready drops. Nothing is lost or repeated.
module indicated_work_integrator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [47:0]                    s_tdata,  // cyl_pressure[19:0], cyl_volume[43:20], zero
  input  logic                           s_tlast,
  input  logic [1:0]                     s_tuser,  // gas_exchange[0], exhaust_stroke[1]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [191:0]                   m_tdata,  // cycle_work, pumping_work, exhaust_work
  output logic                           m_tlast,
  output logic                           m_tuser,  // sample_taken[0]
  input  logic                           cfg_we,
  input  logic [iwi_pkg::PRESS_W-1:0]    cfg_data
);
  import iwi_pkg::*;

  logic [PRESS_W-1:0] ambient;
  logic [PRESS_W-1:0] in_pressure;
  logic [VOL_W-1:0]   in_volume;
  logic               in_boundary;
  logic               in_gas;
  logic               in_exh;
  logic               v1;
  logic               v2;
  logic               ready2;
  logic               ready3;
  inc_t               inc_stage;
  logic [WORK_W-1:0]  cycle_work;
  logic [WORK_W-1:0]  pumping_work;
  logic [WORK_W-1:0]  exhaust_work;

  // Ambient pressure configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ambient <= AMBIENT_RESET;
    end else if (cfg_we) begin
      ambient <= cfg_data;
    end
  end

  // Each stage advances when the one after it is empty or moving.
  assign ready3   = !m_tvalid || m_tready;
  assign ready2   = !v2 || ready3;
  assign s_tready = !v1 || ready2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        v1 <= s_tvalid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        m_tvalid <= v2;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_pressure <= s_tdata[PRESS_W-1:0];
      in_volume   <= s_tdata[PRESS_W+VOL_W-1:PRESS_W];
      in_boundary <= s_tlast;
      in_gas      <= s_tuser[0];
      in_exh      <= s_tuser[1];
    end
  end

  iwi_increment u_increment (
    .clk      (clk),
    .rst      (rst),
    .load     (v1 && ready2),
    .ambient  (ambient),
    .pressure (in_pressure),
    .volume   (in_volume),
    .boundary (in_boundary),
    .gas      (in_gas),
    .exh      (in_exh),
    .stage    (inc_stage)
  );

  iwi_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .load         (v2 && ready3),
    .stage        (inc_stage),
    .sample_taken (m_tuser),
    .cycle_closed (m_tlast),
    .cycle_work   (cycle_work),
    .pumping_work (pumping_work),
    .exhaust_work (exhaust_work)
  );

  assign m_tdata = {exhaust_work, pumping_work, cycle_work};

  // A closed cycle always comes from a used sample.
  a_close_needs_sample: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("cycle closed on an ignored sample");

  // A stalled product-stage item is never dropped.
  a_stage2_held: assert property (@(posedge clk) disable iff (rst)
    v2 && !ready3 |=> v2)
    else $error("product stage lost an item");

  // A closing increment only exists once a previous sample was stored.
  a_close_primed: assert property (@(posedge clk) disable iff (rst)
    v2 && inc_stage.close |-> inc_stage.do_inc && inc_stage.taken)
    else $error("cycle close without an increment");

endmodule
